// ===== hw/rtl/ipwc_pkg.sv =====
// ----------------------------------------------------------------------------
// ipwc_pkg
// Shared types and constants of the ir pulse width capture block: command and
// event codes, register indexes, register widths, reset values and result queue sizes.
// ----------------------------------------------------------------------------
package ipwc_pkg;

    // command carried by the op field
    typedef enum logic {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } op_t;

    // kind of one result transaction
    typedef enum logic [1:0] {
        EV_PULSE     = 2'd0,
        EV_FRAME_END = 2'd1,
        EV_FINISHED  = 2'd2,
        EV_ERROR     = 2'd3
    } event_kind_t;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUIET_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_WANTED = 2'd2;

    localparam int CFG_DATA_W = 16;
    localparam int PERIOD_W   = 10;
    localparam int QUIET_W    = 16;
    localparam int FRAMES_W   = 16;

    localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RESET = 10'd10;
    localparam logic [QUIET_W-1:0]  QUIET_LIMIT_RESET   = 16'd1000;
    localparam logic [FRAMES_W-1:0] FRAMES_WANTED_RESET = 16'd1;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int CNT_W      = 3;

endpackage

// ===== hw/rtl/ir_pulse_width_capture.sv =====
// ----------------------------------------------------------------------------
// ir_pulse_width_capture
// Measures pulse widths on an idle-high infrared receiver line, one sample
// tick per input transaction, and reports pulses, frame ends, finish and
// error events.
// ----------------------------------------------------------------------------
// Each input transaction is handled in the cycle it is accepted: the capture
// state is updated at that edge and its zero, one or two results are written
// into a four-entry result queue, so a new transaction can be taken every
// cycle while in_ready is high. in_ready is high while the queue has room for
// two results; results are offered on the output from the registered queue,
// behind any results still waiting in it. Sustained rate is one transaction
// per cycle as long as the consumer takes one result per cycle; transactions
// that give two results are limited by the single output port of the queue.
module ir_pulse_width_capture
    import ipwc_pkg::*;
#(
    parameter int DURATION_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_write,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,

    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     op,
    input  logic                     pin_level,

    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               event_kind,
    output logic [DURATION_BITS-1:0] duration_us,
    output logic                     last
);

    localparam int SUM_W = ((DURATION_BITS > PERIOD_W) ? DURATION_BITS : PERIOD_W) + 1;
    localparam logic [SUM_W-1:0] DUR_MAX_EXT =
        SUM_W'((64'd1 << DURATION_BITS) - 64'd1);
    localparam logic [DURATION_BITS-1:0] DUR_MAX = DURATION_BITS'(DUR_MAX_EXT);
    localparam logic [QUIET_W-1:0] QUIET_MAX = '1;
    localparam logic [CNT_W-1:0] ROOM_FOR_TWO = CNT_W'(FIFO_DEPTH - 2);

    typedef enum logic [1:0] {
        PH_WAIT    = 2'd0,
        PH_CAPTURE = 2'd1,
        PH_DONE    = 2'd2,
        PH_ERROR   = 2'd3
    } phase_t;

    typedef struct packed {
        event_kind_t              kind;
        logic [DURATION_BITS-1:0] duration;
        logic                     last;
    } res_t;

    // configuration registers
    logic [PERIOD_W-1:0]      sample_period_reg;
    logic [QUIET_W-1:0]       quiet_limit_reg;
    logic [FRAMES_W-1:0]      frames_wanted_reg;

    // capture state
    phase_t                   phase_reg,   phase_next;
    logic                     level_reg,   level_next;
    logic [DURATION_BITS-1:0] elapsed_reg, elapsed_next;
    logic [QUIET_W-1:0]       quiet_reg,   quiet_next;
    logic                     armed_reg,   armed_next;
    logic [FRAMES_W-1:0]      frames_reg,  frames_next;

    // state as seen by a tick, after a possible start of capture
    logic                     detect;
    phase_t                   eff_phase;
    logic                     eff_level;
    logic [DURATION_BITS-1:0] eff_elapsed;
    logic [QUIET_W-1:0]       eff_quiet;
    logic                     eff_armed;
    logic [FRAMES_W-1:0]      eff_frames;

    logic                     fire;
    logic                     pin_edge;
    logic [FRAMES_W-1:0]      frames_dec;
    logic [DURATION_BITS-1:0] elapsed_base;
    logic [QUIET_W-1:0]       quiet_base;
    logic [SUM_W-1:0]         elapsed_sum;

    res_t                     res0, res1;
    logic [1:0]               res_n;

    // result queue
    res_t                     fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]         fifo_cnt_reg;
    logic                     accept;
    logic                     pop;
    logic [1:0]               push_n;
    res_t                     head;

    assign accept = in_valid && in_ready;
    assign pop    = out_valid && out_ready;
    assign push_n = accept ? res_n : 2'd0;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_period_reg <= SAMPLE_PERIOD_RESET;
            quiet_limit_reg   <= QUIET_LIMIT_RESET;
            frames_wanted_reg <= FRAMES_WANTED_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SAMPLE_PERIOD: sample_period_reg <= cfg_data[PERIOD_W-1:0];
                REG_QUIET_LIMIT:   quiet_limit_reg   <= cfg_data[QUIET_W-1:0];
                REG_FRAMES_WANTED: frames_wanted_reg <= cfg_data[FRAMES_W-1:0];
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // tick view of the state: first low while waiting starts capture
    // ------------------------------------------------------------------
    always_comb
    begin
        detect = (phase_reg == PH_WAIT) && !pin_level;
        if (detect)
        begin
            eff_phase   = PH_CAPTURE;
            eff_level   = 1'b0;
            eff_elapsed = '0;
            eff_quiet   = '0;
            eff_armed   = 1'b1;
            eff_frames  = (frames_wanted_reg == '0) ? FRAMES_W'(1) : frames_wanted_reg;
        end
        else
        begin
            eff_phase   = phase_reg;
            eff_level   = level_reg;
            eff_elapsed = elapsed_reg;
            eff_quiet   = quiet_reg;
            eff_armed   = armed_reg;
            eff_frames  = frames_reg;
        end

        fire       = eff_armed && (eff_quiet >= quiet_limit_reg);
        pin_edge   = (pin_level != eff_level);
        frames_dec = (eff_frames != '0) ? eff_frames - FRAMES_W'(1) : '0;

        elapsed_base = pin_edge ? '0 : eff_elapsed;
        quiet_base   = pin_edge ? '0 : eff_quiet;
        elapsed_sum  = SUM_W'(elapsed_base) + SUM_W'(sample_period_reg);
    end

    // ------------------------------------------------------------------
    // state update and results of one transaction
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next   = phase_reg;
        level_next   = level_reg;
        elapsed_next = elapsed_reg;
        quiet_next   = quiet_reg;
        armed_next   = armed_reg;
        frames_next  = frames_reg;
        res0         = '{kind: EV_PULSE, duration: '0, last: 1'b0};
        res1         = '{kind: EV_PULSE, duration: '0, last: 1'b1};
        res_n        = 2'd0;

        if (op_t'(op) == OP_START)
        begin
            phase_next   = PH_WAIT;
            level_next   = 1'b0;
            elapsed_next = '0;
            quiet_next   = '0;
            armed_next   = 1'b1;
        end
        else if (eff_phase == PH_CAPTURE)
        begin
            phase_next   = eff_phase;
            level_next   = eff_level;
            elapsed_next = eff_elapsed;
            quiet_next   = eff_quiet;
            armed_next   = eff_armed;
            frames_next  = eff_frames;

            priority if (fire && !eff_level)
            begin
                // line held low too long
                phase_next = PH_ERROR;
                res0.kind  = EV_ERROR;
                res_n      = 2'd1;
            end
            else if (fire && (frames_dec == '0))
            begin
                phase_next  = PH_DONE;
                armed_next  = 1'b0;
                frames_next = frames_dec;
                res0.kind   = EV_FINISHED;
                res_n       = 2'd1;
            end
            else
            begin
                if (fire)
                begin
                    armed_next  = 1'b0;
                    frames_next = frames_dec;
                end
                if (pin_edge)
                begin
                    level_next = pin_level;
                    armed_next = 1'b1;
                end
                elapsed_next = (elapsed_sum > DUR_MAX_EXT) ? DUR_MAX
                                                            : elapsed_sum[DURATION_BITS-1:0];
                quiet_next   = (quiet_base == QUIET_MAX) ? QUIET_MAX
                                                         : quiet_base + QUIET_W'(1);

                // frame end comes ahead of the pulse of the same tick
                if (fire && pin_edge)
                begin
                    res0.kind     = EV_FRAME_END;
                    res1.kind     = EV_PULSE;
                    res1.duration = eff_elapsed;
                    res_n         = 2'd2;
                end
                else if (fire)
                begin
                    res0.kind = EV_FRAME_END;
                    res_n     = 2'd1;
                end
                else if (pin_edge)
                begin
                    res0.duration = eff_elapsed;
                    res_n         = 2'd1;
                end
            end
        end

        res0.last = (res_n == 2'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_WAIT;
            level_reg   <= 1'b0;
            elapsed_reg <= '0;
            quiet_reg   <= '0;
            armed_reg   <= 1'b1;
            frames_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            level_reg   <= level_next;
            elapsed_reg <= elapsed_next;
            quiet_reg   <= quiet_next;
            armed_reg   <= armed_next;
            frames_reg  <= frames_next;
        end
    end

    // ------------------------------------------------------------------
    // result queue
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            fifo_mem[wr_ptr_reg] <= res0;
        end
        if (push_n == 2'd2)
        begin
            fifo_mem[wr_ptr_reg + PTR_W'(1)] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg   <= wr_ptr_reg + PTR_W'(push_n);
            rd_ptr_reg   <= rd_ptr_reg + PTR_W'(pop);
            fifo_cnt_reg <= fifo_cnt_reg + CNT_W'(push_n) - CNT_W'(pop);
        end
    end

    assign in_ready    = (fifo_cnt_reg <= ROOM_FOR_TWO);
    assign out_valid   = (fifo_cnt_reg != '0);
    assign head        = fifo_mem[rd_ptr_reg];
    assign event_kind  = head.kind;
    assign duration_us = head.duration;
    assign last        = head.last;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_cnt_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_fifo_count: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> fifo_cnt_reg == $past(fifo_cnt_reg) + CNT_W'($past(push_n))
                                 - CNT_W'($past(pop)))
        else $error("result queue count lost track of pushes and pops");

    a_start_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op_t'(op) == OP_START)) |=> (phase_reg == PH_WAIT) && armed_reg)
        else $error("start transaction did not rearm capture");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op_t'(op) == OP_TICK) && (phase_reg == PH_ERROR))
        |=> (phase_reg == PH_ERROR) && (fifo_cnt_reg <= $past(fifo_cnt_reg)))
        else $error("tick in error phase changed state or produced a result");

endmodule
